// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion helpers, sampled on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== hw/rtl/ael_pkg.sv =====
// ----------------------------------------------------------------------------
// ael_pkg
// shared types and constants of the expression line lexer
// ----------------------------------------------------------------------------
package ael_pkg;

  // parameter defaults
  localparam int MAX_LINE_DEF    = 1024;
  localparam int MAX_TOKENS_DEF  = 64;
  localparam int MANT_BITS_DEF   = 32;

  // configuration port
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARAM_PREFIX = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_OFFSET = 1'b1;
  localparam logic [7:0]            PREFIX_RESET     = 8'd80;
  localparam logic [CFG_DATA_W-1:0] OFFSET_RESET     = '0;

  // mnemonics
  localparam int MN_COUNT = 5;
  localparam int MN_IDX_W = $clog2(MN_COUNT);

  // classifier queue
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    K_VALUE   = 4'd0,
    K_PARAM   = 4'd1,
    K_EQUALS  = 4'd2,
    K_PLUS    = 4'd3,
    K_MINUS   = 4'd4,
    K_MUL     = 4'd5,
    K_DIV     = 4'd6,
    K_END     = 4'd7,
    K_STOPPED = 4'd8,
    K_LIMIT   = 4'd9
  } kind_t;

  // character class produced by the front end
  typedef struct packed {
    logic                zero;
    logic                space;
    logic                digit;
    logic [3:0]          dval;
    logic                point;
    logic                prefix;
    logic                op_hit;
    kind_t               op_kind;
    logic                mn_hit;
    logic [MN_IDX_W-1:0] mn_idx;
    logic [MN_COUNT-1:0] sec_match;
    logic [MN_COUNT-1:0] third_match;
  } cls_t;

endpackage

// ===== hw/rtl/arithmetic_expression_lexer.sv =====
// ----------------------------------------------------------------------------
// arithmetic_expression_lexer
// character-at-a-time lexer for expression lines: values, parameter refs,
// operators and mnemonics, with end, stop and limit reports
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  ch       | in        | ch_valid / ch_stall  | ch
//  tok      | out       | tok_valid / tok_stall| token_kind mantissa frac_digits
//           |           |                      | stop_position last_of_item
//  cfg      | in        | cfg_we               | cfg_index cfg_data
//
//  one character per cycle sustained while each character gives at most one
//  token and tok_stall is low; a character giving several tokens holds the
//  scanner until its last token leaves, its tokens leaving the burst register
//  one per cycle while tok_stall is low. an accepted character passes a queue
//  entry, then the burst register. reset is synchronous; no clearing pass.
//  tok_stall holds the burst; ch_stall rises once the two-entry queue fills.
// ----------------------------------------------------------------------------
module arithmetic_expression_lexer #(
  parameter int MAX_LINE    = ael_pkg::MAX_LINE_DEF,
  parameter int MAX_TOKENS  = ael_pkg::MAX_TOKENS_DEF,
  parameter int MANT_BITS   = ael_pkg::MANT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ael_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ael_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                      ch,
  input  logic                            ch_valid,
  output logic                            ch_stall,
  output logic [3:0]                      token_kind,
  output logic [31:0]                     mantissa,
  output logic [3:0]                      frac_digits,
  output logic [9:0]                      stop_position,
  output logic                            last_of_item,
  output logic                            tok_valid,
  input  logic                            tok_stall
);
  import ael_pkg::*;

  cls_t front_cls;
  cls_t q_head;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  ael_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ch        (ch),
    .ch_valid  (ch_valid),
    .ch_stall  (ch_stall),
    .q_full    (q_full),
    .push      (push),
    .cls       (front_cls)
  );

  ael_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ael_back #(
    .MAX_LINE    (MAX_LINE),
    .MAX_TOKENS  (MAX_TOKENS),
    .MANT_BITS   (MANT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .head          (q_head),
    .pop           (pop),
    .tok_valid     (tok_valid),
    .tok_stall     (tok_stall),
    .token_kind    (token_kind),
    .mantissa      (mantissa),
    .frac_digits   (frac_digits),
    .stop_position (stop_position),
    .last_of_item  (last_of_item)
  );

endmodule

// ===== hw/rtl/ael_front.sv =====
// ----------------------------------------------------------------------------
// ael_front
// accepts characters and classifies them for the scanner
// ----------------------------------------------------------------------------
module ael_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ael_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ael_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                      ch,
  input  logic                            ch_valid,
  output logic                            ch_stall,
  input  logic                            q_full,
  output logic                            push,
  output ael_pkg::cls_t                   cls
);
  import ael_pkg::*;

  localparam logic [7:0] CH_DIGIT_0 = 8'd48;
  localparam logic [7:0] CH_DIGIT_9 = 8'd57;
  localparam logic [7:0] CH_POINT   = 8'd46;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_EQ      = 8'd61;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_STAR    = 8'd42;
  localparam logic [7:0] CH_SLASH   = 8'd47;

  // EQU ADD SUB MUL DIV, letter by letter
  localparam logic [7:0] MN_FIRST  [MN_COUNT] = '{8'd69, 8'd65, 8'd83, 8'd77, 8'd68};
  localparam logic [7:0] MN_SECOND [MN_COUNT] = '{8'd81, 8'd68, 8'd85, 8'd85, 8'd73};
  localparam logic [7:0] MN_THIRD  [MN_COUNT] = '{8'd85, 8'd68, 8'd66, 8'd76, 8'd86};

  logic [7:0] prefix_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_reg <= PREFIX_RESET;
    end else if (cfg_we && cfg_index == CFG_PARAM_PREFIX) begin
      prefix_reg <= cfg_data[7:0];
    end
  end

  assign ch_stall = q_full;
  assign push     = ch_valid && !q_full;

  always_comb begin
    cls        = '0;
    cls.zero   = (ch == 8'd0);
    cls.space  = (ch == CH_SPACE);
    cls.digit  = ch inside {[CH_DIGIT_0:CH_DIGIT_9]};
    cls.dval   = 4'(ch - CH_DIGIT_0);
    cls.point  = (ch == CH_POINT);
    cls.prefix = (ch == prefix_reg);
    cls.op_hit = 1'b1;
    case (ch)
      CH_EQ:    cls.op_kind = K_EQUALS;
      CH_PLUS:  cls.op_kind = K_PLUS;
      CH_MINUS: cls.op_kind = K_MINUS;
      CH_STAR:  cls.op_kind = K_MUL;
      CH_SLASH: cls.op_kind = K_DIV;
      default: begin
        cls.op_hit  = 1'b0;
        cls.op_kind = K_VALUE;
      end
    endcase
    for (int k = MN_COUNT - 1; k >= 0; k--) begin
      if (ch == MN_FIRST[k]) begin
        cls.mn_hit = 1'b1;
        cls.mn_idx = MN_IDX_W'(k);
      end
      cls.sec_match[k]   = (ch == MN_SECOND[k]);
      cls.third_match[k] = (ch == MN_THIRD[k]);
    end
  end

endmodule

// ===== hw/rtl/ael_queue.sv =====
// ----------------------------------------------------------------------------
// ael_queue
// short register queue of classified characters between front and back
// ----------------------------------------------------------------------------
module ael_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ael_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ael_pkg::cls_t head
);
  import ael_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cls_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/ael_back.sv =====
// ----------------------------------------------------------------------------
// ael_back
// token scanner: carries out one classified character per cycle while the burst
// register is empty or its last token leaves, and drains its tokens from a three-slot burst register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ael_back #(
  parameter int MAX_LINE    = ael_pkg::MAX_LINE_DEF,
  parameter int MAX_TOKENS  = ael_pkg::MAX_TOKENS_DEF,
  parameter int MANT_BITS   = ael_pkg::MANT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ael_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ael_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            q_valid,
  input  ael_pkg::cls_t                   head,
  output logic                            pop,
  output logic                            tok_valid,
  input  logic                            tok_stall,
  output logic [3:0]                      token_kind,
  output logic [31:0]                     mantissa,
  output logic [3:0]                      frac_digits,
  output logic [9:0]                      stop_position,
  output logic                            last_of_item
);
  import ael_pkg::*;

  localparam int PW   = ($clog2(MAX_LINE) > CFG_DATA_W) ? $clog2(MAX_LINE) : CFG_DATA_W;
  localparam int TW   = $clog2(MAX_TOKENS + 1);
  localparam int AW   = MANT_BITS + 4;
  localparam int NRES = 3;
  localparam logic [PW-1:0] POS_LAST  = PW'(MAX_LINE - 1);
  localparam logic [TW-1:0] TOK_LIMIT = TW'(MAX_TOKENS);

  typedef enum logic [2:0] {
    M_IDLE, M_INT, M_FRAC, M_PARAM, M_VINT, M_FIRST, M_SECOND, M_HALT
  } mode_t;

  // saturating acc*10+d, the times ten as two shifts
  function automatic logic [MANT_BITS-1:0] acc_step(input logic [MANT_BITS-1:0] a,
                                                    input logic [3:0] d);
    logic [AW-1:0] w;
    w = (AW'(a) << 3) + (AW'(a) << 1) + AW'(d);
    if (w[AW-1:MANT_BITS] != 4'd0) begin
      return '1;
    end
    return w[MANT_BITS-1:0];
  endfunction

  mode_t                 mode, mode_n;
  logic [MN_IDX_W-1:0]   mn, mn_n;
  logic [MANT_BITS-1:0]  acc, acc_n;
  logic [3:0]            frac, frac_n;
  logic [TW-1:0]         tok, tok_n;
  logic [PW-1:0]         pos, pos_n;
  logic [PW-1:0]         pend, pend_n;
  logic                  started;
  logic [CFG_DATA_W-1:0] start_off;
  logic [1:0]            left;

  kind_t      r_kind [NRES];
  logic [31:0] r_mant [NRES];
  logic [3:0]  r_frac [NRES];
  logic [9:0]  r_pos  [NRES];
  logic [1:0]  cnt;
  logic        halt, rearm, scan_idle;

  kind_t      b_kind [NRES];
  logic [31:0] b_mant [NRES];
  logic [3:0]  b_frac [NRES];
  logic [9:0]  b_pos  [NRES];

  logic fire;

  assign tok_valid     = (left != 2'd0);
  assign fire          = tok_valid && !tok_stall;
  assign pop           = q_valid && (left == 2'd0 || (left == 2'd1 && !tok_stall));
  assign token_kind    = b_kind[0];
  assign mantissa      = b_mant[0];
  assign frac_digits   = b_frac[0];
  assign stop_position = b_pos[0];
  assign last_of_item  = (left == 2'd1);

  always_comb begin
    mode_n    = mode;
    mn_n      = mn;
    acc_n     = acc;
    frac_n    = frac;
    tok_n     = tok;
    pend_n    = pend;
    pos_n     = pos;
    halt      = 1'b0;
    rearm     = 1'b0;
    scan_idle = 1'b0;
    cnt       = 2'd0;
    for (int i = 0; i < NRES; i++) begin
      r_kind[i] = K_VALUE;
      r_mant[i] = '0;
      r_frac[i] = '0;
      r_pos[i]  = '0;
    end

    case (mode)
      M_INT, M_FRAC, M_PARAM, M_VINT: begin
        if (head.digit) begin
          if (mode != M_FRAC) begin
            acc_n = acc_step(acc, head.dval);
          end else if (frac < 4'd9) begin
            acc_n  = acc_step(acc, head.dval);
            frac_n = frac + 4'd1;
          end
        end else if (mode == M_INT && head.point) begin
          mode_n = M_FRAC;
        end else begin
          // number ends here, the character is then scanned as a token start
          mode_n      = M_IDLE;
          r_kind[cnt] = (mode == M_PARAM) ? K_PARAM : K_VALUE;
          r_mant[cnt] = 32'(acc);
          r_frac[cnt] = (mode == M_FRAC) ? frac : 4'd0;
          cnt         = cnt + 2'd1;
          tok_n       = tok_n + TW'(1);
          if (tok_n >= TOK_LIMIT) begin
            r_kind[cnt] = K_LIMIT;
            r_pos[cnt]  = pos[9:0];
            cnt         = cnt + 2'd1;
            halt        = 1'b1;
          end else begin
            scan_idle = 1'b1;
          end
        end
      end
      M_FIRST: begin
        if (head.sec_match[mn]) begin
          mode_n = M_SECOND;
        end else begin
          r_kind[cnt] = K_STOPPED;
          r_pos[cnt]  = pend[9:0];
          cnt         = cnt + 2'd1;
          halt        = 1'b1;
        end
      end
      M_SECOND: begin
        if (head.third_match[mn]) begin
          mode_n      = M_IDLE;
          r_kind[cnt] = kind_t'(4'(K_EQUALS) + 4'(mn));
          cnt         = cnt + 2'd1;
          tok_n       = tok_n + TW'(1);
          if (tok_n >= TOK_LIMIT) begin
            r_kind[cnt] = K_LIMIT;
            r_pos[cnt]  = pos[9:0];
            cnt         = cnt + 2'd1;
            halt        = 1'b1;
          end
        end else begin
          r_kind[cnt] = K_STOPPED;
          r_pos[cnt]  = pend[9:0];
          cnt         = cnt + 2'd1;
          halt        = 1'b1;
        end
      end
      M_HALT: begin
        rearm = head.zero;
      end
      default: begin
        // idle between tokens
        scan_idle = 1'b1;
      end
    endcase

    if (scan_idle) begin
      if (pos >= POS_LAST) begin
        r_kind[cnt] = K_LIMIT;
        r_pos[cnt]  = pos[9:0];
        cnt         = cnt + 2'd1;
        halt        = 1'b1;
      end else if (head.zero) begin
        r_kind[cnt] = K_END;
        cnt         = cnt + 2'd1;
        rearm       = 1'b1;
      end else if (head.space) begin
        mode_n = mode_n;
      end else if (head.digit) begin
        frac_n = 4'd0;
        if (head.prefix) begin
          // prefix digit is swallowed, the rest is a plain integer
          mode_n = M_VINT;
          acc_n  = '0;
        end else begin
          mode_n = M_INT;
          acc_n  = acc_step('0, head.dval);
        end
      end else if (head.prefix) begin
        mode_n = M_PARAM;
        acc_n  = '0;
        frac_n = 4'd0;
      end else if (head.op_hit) begin
        r_kind[cnt] = head.op_kind;
        cnt         = cnt + 2'd1;
        tok_n       = tok_n + TW'(1);
        if (tok_n >= TOK_LIMIT) begin
          r_kind[cnt] = K_LIMIT;
          r_pos[cnt]  = pos[9:0];
          cnt         = cnt + 2'd1;
          halt        = 1'b1;
        end
      end else if (head.mn_hit) begin
        mode_n = M_FIRST;
        mn_n   = head.mn_idx;
        pend_n = pos;
      end else begin
        r_kind[cnt] = K_STOPPED;
        r_pos[cnt]  = pos[9:0];
        cnt         = cnt + 2'd1;
        halt        = 1'b1;
      end
    end

    if (halt) begin
      mode_n = M_HALT;
      if (head.zero) begin
        rearm = 1'b1;
      end
    end

    if (rearm) begin
      mode_n = M_IDLE;
      acc_n  = '0;
      frac_n = 4'd0;
      tok_n  = '0;
      pos_n  = PW'(start_off);
    end else if (pos < POS_LAST) begin
      pos_n = pos + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      mn        <= '0;
      acc       <= '0;
      frac      <= 4'd0;
      tok       <= '0;
      pos       <= PW'(OFFSET_RESET);
      pend      <= '0;
      started   <= 1'b0;
      start_off <= OFFSET_RESET;
      left      <= 2'd0;
    end else begin
      if (cfg_we && cfg_index == CFG_START_OFFSET) begin
        start_off <= cfg_data;
      end
      if (pop) begin
        mode    <= mode_n;
        mn      <= mn_n;
        acc     <= acc_n;
        frac    <= frac_n;
        tok     <= tok_n;
        pos     <= pos_n;
        pend    <= pend_n;
        started <= !rearm;
        left    <= cnt;
      end else begin
        if (cfg_we && cfg_index == CFG_START_OFFSET && !started) begin
          pos <= PW'(cfg_data);
        end
        if (fire) begin
          left <= left - 2'd1;
        end
      end
    end

    // burst payload, no reset
    if (pop) begin
      for (int i = 0; i < NRES; i++) begin
        b_kind[i] <= r_kind[i];
        b_mant[i] <= r_mant[i];
        b_frac[i] <= r_frac[i];
        b_pos[i]  <= r_pos[i];
      end
    end else if (fire) begin
      for (int i = 0; i < NRES - 1; i++) begin
        b_kind[i] <= b_kind[i+1];
        b_mant[i] <= b_mant[i+1];
        b_frac[i] <= b_frac[i+1];
        b_pos[i]  <= b_pos[i+1];
      end
    end
  end

  `ASSERT_CLK(a_halt_quiet, pop && mode == M_HALT && !head.zero |=> !tok_valid, "token after halt")
  `ASSERT_CLK(a_tok_bound, mode != M_HALT |-> tok < TOK_LIMIT, "token count at limit")
  `ASSERT_NEVER(a_frac_bound, frac > 4'd9, "fraction digit count above nine")

endmodule

// ===== dv/lexer_token_pkg.sv =====
// ----------------------------------------------------------------------------
// lexer_token_pkg
// character codes, token record and the token scoreboard of the expression
// line lexer test: predicts the tokens of each accepted character and checks
// every token that leaves the block against the oldest prediction
// ----------------------------------------------------------------------------
package lexer_token_pkg;
  import ael_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_POINT  = ".";
  localparam logic [7:0] CH_DIGIT0 = "0";
  localparam logic [7:0] CH_DIGIT9 = "9";
  localparam logic [7:0] CH_EQUALS = "=";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";

  // in token kind order, starting at equals
  localparam logic [23:0] MNEMONICS [MN_COUNT] = '{"EQU", "ADD", "SUB", "MUL", "DIV"};

  localparam int MAX_FRAC  = 9;
  localparam int MAX_BURST = 3;
  localparam longint unsigned MANT_MAX =
    ((64'd1 << (MANT_BITS_DEF - 1)) * 64'd2) - 64'd1;

  typedef struct {
    kind_t       kind;
    logic [31:0] mant;
    logic [3:0]  frac;
    logic [9:0]  pos;
    logic        last;
  } token_t;

  typedef enum {
    SCAN_IDLE,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_PARAM,
    SCAN_SKIP_PREFIX,
    SCAN_MN_SECOND,
    SCAN_MN_THIRD,
    SCAN_HALTED
  } scan_t;

  function automatic logic [7:0] mn_letter(int k, int j);
    return MNEMONICS[k][8*(2-j) +: 8];
  endfunction

  class token_scoreboard;
    token_t          expected_tokens[$];
    token_t          burst[$];
    int              errors;
    logic [7:0]      prefix;
    int              offset;
    scan_t           mode;
    int              mn_sel;
    longint unsigned accum;
    int              frac_cnt;
    int              tok_cnt;
    int              line_pos;
    int              mn_pos;
    bit              line_started;

    function new();
      errors       = 0;
      prefix       = PREFIX_RESET;
      offset       = int'(OFFSET_RESET);
      mode         = SCAN_IDLE;
      mn_sel       = 0;
      accum        = 0;
      frac_cnt     = 0;
      tok_cnt      = 0;
      line_pos     = offset;
      mn_pos       = 0;
      line_started = 1'b0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PARAM_PREFIX) begin
        prefix = data[7:0];
      end else begin
        offset = int'(data);
        if (!line_started) line_pos = offset;
      end
    endfunction

    function void add_result(kind_t k, longint unsigned m, int f, int p);
      token_t t;
      if (burst.size() >= MAX_BURST) return;
      t.kind = k;
      t.mant = m[31:0];
      t.frac = f[3:0];
      t.pos  = p[9:0];
      t.last = 1'b0;
      burst.push_back(t);
    endfunction

    // counted token; true once the line has reached the token limit
    function bit add_token(kind_t k, longint unsigned m, int f);
      add_result(k, m, f, 0);
      tok_cnt++;
      return tok_cnt >= MAX_TOKENS_DEF;
    endfunction

    function void add_digit(int d);
      if (accum > (MANT_MAX - longint'(d)) / 64'd10) accum = MANT_MAX;
      else accum = accum * 64'd10 + longint'(d);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_DIGIT0 && c <= CH_DIGIT9;
    endfunction

    function void note_char(logic [7:0] c);
      int    pos;
      int    dval;
      int    found;
      int    frac_out;
      bit    scan_now;
      bit    halt;
      bit    rearm;
      bit    op_hit;
      kind_t opk;
      kind_t num_kind;
      pos          = line_pos;
      dval         = int'(c) - int'(CH_DIGIT0);
      found        = -1;
      scan_now     = 1'b0;
      halt         = 1'b0;
      rearm        = 1'b0;
      op_hit       = 1'b1;
      opk          = K_EQUALS;
      burst.delete();
      line_started = 1'b1;

      case (mode)
        SCAN_INT, SCAN_FRAC, SCAN_PARAM, SCAN_SKIP_PREFIX: begin
          if (is_digit(c)) begin
            if (mode != SCAN_FRAC) begin
              add_digit(dval);
            end else if (frac_cnt < MAX_FRAC) begin
              add_digit(dval);
              frac_cnt++;
            end
          end else if (mode == SCAN_INT && c == CH_POINT) begin
            mode = SCAN_FRAC;
          end else begin
            // number ends here, the character is then scanned as a new token
            num_kind = (mode == SCAN_PARAM) ? K_PARAM : K_VALUE;
            frac_out = (mode == SCAN_FRAC) ? frac_cnt : 0;
            mode = SCAN_IDLE;
            if (add_token(num_kind, accum, frac_out)) begin
              add_result(K_LIMIT, 0, 0, pos);
              halt = 1'b1;
            end else begin
              scan_now = 1'b1;
            end
          end
        end
        SCAN_MN_SECOND: begin
          if (c == mn_letter(mn_sel, 1)) begin
            mode = SCAN_MN_THIRD;
          end else begin
            add_result(K_STOPPED, 0, 0, mn_pos);
            halt = 1'b1;
          end
        end
        SCAN_MN_THIRD: begin
          if (c == mn_letter(mn_sel, 2)) begin
            mode = SCAN_IDLE;
            if (add_token(kind_t'(int'(K_EQUALS) + mn_sel), 0, 0)) begin
              add_result(K_LIMIT, 0, 0, pos);
              halt = 1'b1;
            end
          end else begin
            add_result(K_STOPPED, 0, 0, mn_pos);
            halt = 1'b1;
          end
        end
        SCAN_HALTED: begin
          if (c == CH_NUL) rearm = 1'b1;
        end
        default: begin
          scan_now = 1'b1;
        end
      endcase

      if (scan_now) begin
        if (pos >= MAX_LINE_DEF - 1) begin
          add_result(K_LIMIT, 0, 0, pos);
          halt = 1'b1;
        end else if (c == CH_NUL) begin
          add_result(K_END, 0, 0, 0);
          rearm = 1'b1;
        end else if (c == CH_SPACE) begin
          // skipped
        end else if (is_digit(c)) begin
          frac_cnt = 0;
          accum    = 0;
          if (c == prefix) begin
            mode = SCAN_SKIP_PREFIX;
          end else begin
            mode = SCAN_INT;
            add_digit(dval);
          end
        end else if (c == prefix) begin
          mode     = SCAN_PARAM;
          accum    = 0;
          frac_cnt = 0;
        end else begin
          case (c)
            CH_EQUALS: opk = K_EQUALS;
            CH_PLUS:   opk = K_PLUS;
            CH_MINUS:  opk = K_MINUS;
            CH_STAR:   opk = K_MUL;
            CH_SLASH:  opk = K_DIV;
            default:   op_hit = 1'b0;
          endcase
          if (op_hit) begin
            if (add_token(opk, 0, 0)) begin
              add_result(K_LIMIT, 0, 0, pos);
              halt = 1'b1;
            end
          end else begin
            for (int k = 0; k < MN_COUNT; k++) begin
              if (found < 0 && c == mn_letter(k, 0)) found = k;
            end
            if (found >= 0) begin
              mode   = SCAN_MN_SECOND;
              mn_sel = found;
              mn_pos = pos;
            end else begin
              add_result(K_STOPPED, 0, 0, pos);
              halt = 1'b1;
            end
          end
        end
      end

      if (halt) begin
        mode = SCAN_HALTED;
        if (c == CH_NUL) rearm = 1'b1;
      end

      if (rearm) begin
        mode         = SCAN_IDLE;
        accum        = 0;
        frac_cnt     = 0;
        tok_cnt      = 0;
        line_pos     = offset;
        line_started = 1'b0;
      end else if (pos < MAX_LINE_DEF - 1) begin
        line_pos = pos + 1;
      end

      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected_tokens.push_back(burst[i]);
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got,
                         longint unsigned now);
      errors++;
      $display("%0d ns: %s expected %0d actual %0d", now, field, want, got);
    endfunction

    function void check(token_t got, longint unsigned now);
      token_t want;
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0d ns: token with nothing pending, expected none actual kind %0d mantissa %0d",
                 now, got.kind, got.mant);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind) report("token_kind", want.kind, got.kind, now);
      if (got.mant !== want.mant) report("mantissa", want.mant, got.mant, now);
      if (got.frac !== want.frac) report("frac_digits", want.frac, got.frac, now);
      if (got.pos !== want.pos) report("stop_position", want.pos, got.pos, now);
      if (got.last !== want.last) report("last_of_item", want.last, got.last, now);
    endfunction
  endclass

endpackage

// ===== dv/arithmetic_expression_lexer_test.sv =====
// ----------------------------------------------------------------------------
// arithmetic_expression_lexer_test
// feeds expression lines one character per item, with random gaps and stalls
// on both channels, and checks every token against the scoreboard; the run
// steps through several prefix and start offset settings
// ----------------------------------------------------------------------------
module arithmetic_expression_lexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ael_pkg::*;
  import lexer_token_pkg::*;

  localparam int PHASES = 5;
  localparam logic [7:0] PHASE_PREFIX [PHASES] = '{8'd53, 8'd255, 8'd0, 8'd61, 8'd80};
  localparam int PHASE_OFFSET [PHASES] = '{0, 1023, 1010, 512, 0};
  localparam int PHASE_ITEMS [PHASES] = '{110, 140, 220, 300, 460};

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic [7:0]             ch;
  logic                   ch_valid;
  logic                   ch_stall;
  logic [3:0]             token_kind;
  logic [31:0]            mantissa;
  logic [3:0]             frac_digits;
  logic [9:0]             stop_position;
  logic                   last_of_item;
  logic                   tok_valid;
  logic                   tok_stall;

  token_scoreboard sb = new();
  int              items_sent = 0;
  int              tokens_seen = 0;
  bit              fast_sender = 1'b0;
  bit              fast_receiver = 1'b0;
  logic [7:0]      cur_prefix = PREFIX_RESET;

  arithmetic_expression_lexer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ch           (ch),
    .ch_valid     (ch_valid),
    .ch_stall     (ch_stall),
    .token_kind   (token_kind),
    .mantissa     (mantissa),
    .frac_digits  (frac_digits),
    .stop_position(stop_position),
    .last_of_item (last_of_item),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("arithmetic_expression_lexer_test failed");
    $finish;
  end

  function automatic logic [7:0] digit_char();
    return 8'(int'(CH_DIGIT0) + int'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] op_char();
    case ($urandom_range(0, 4))
      0:       return CH_EQUALS;
      1:       return CH_PLUS;
      2:       return CH_MINUS;
      3:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic send_char(logic [7:0] c);
    int gap;
    gap = fast_sender ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      ch_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ch       <= c;
    ch_valid <= 1'b1;
    do @(posedge clk); while (ch_stall);
    sb.note_char(c);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_number();
    int n_int;
    n_int = ($urandom_range(0, 3) == 0) ? int'($urandom_range(8, 12))
                                         : int'($urandom_range(1, 4));
    repeat (n_int) send_char(digit_char());
    if ($urandom_range(0, 1) == 1) begin
      send_char(CH_POINT);
      repeat ($urandom_range(0, 12)) send_char(digit_char());
    end
  endtask

  task automatic send_token();
    int k;
    k = int'($urandom_range(0, MN_COUNT - 1));
    case ($urandom_range(0, 9))
      0, 1, 2: send_number();
      3: begin
        send_char(cur_prefix);
        repeat ($urandom_range(0, 3)) send_char(digit_char());
      end
      4, 5, 6: send_char(op_char());
      7: for (int j = 0; j < 3; j++) send_char(mn_letter(k, j));
      8: repeat ($urandom_range(1, 3)) send_char(CH_SPACE);
      default: begin
        // broken mnemonic or a stray character
        if ($urandom_range(0, 1) == 1) begin
          send_char(mn_letter(k, 0));
          if ($urandom_range(0, 1) == 1) send_char(mn_letter(k, 1));
          send_char(8'($urandom_range(0, 255)));
        end else begin
          send_char(8'($urandom_range(1, 255)));
        end
      end
    endcase
  endtask

  // alternating digits and operators, long enough to reach the token limit
  task automatic send_dense_line();
    int n;
    n = int'($urandom_range(66, 80));
    for (int i = 0; i < n; i++) send_char(i[0] ? op_char() : digit_char());
    send_char(CH_NUL);
  endtask

  task automatic send_line();
    int pick;
    fast_sender = ($urandom_range(0, 3) == 0);
    pick = int'($urandom_range(0, 19));
    if (pick < 15) begin
      repeat ($urandom_range(1, 12)) begin
        send_token();
        if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
      end
      if ($urandom_range(0, 9) != 0) send_char(CH_NUL);
    end else if (pick < 16) begin
      send_dense_line();
    end else begin
      repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) send_char(CH_NUL);
    end
  endtask

  // hold the input until every pending token is out and the pipe is empty
  task automatic settle();
    ch_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] prefix, int offset);
    logic [CFG_DATA_W-1:0] word;
    word      = CFG_DATA_W'($urandom);
    word[7:0] = prefix;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PARAM_PREFIX;
    cfg_data  <= word;
    @(posedge clk);
    sb.write_reg(CFG_PARAM_PREFIX, word);
    cfg_index <= CFG_START_OFFSET;
    cfg_data  <= CFG_DATA_W'(offset);
    @(posedge clk);
    sb.write_reg(CFG_START_OFFSET, CFG_DATA_W'(offset));
    cfg_we     <= 1'b0;
    cur_prefix = prefix;
  endtask

  // token side
  initial begin
    int     wait_cycles;
    token_t got;
    tok_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (tokens_seen % 16 == 0) fast_receiver = ($urandom_range(0, 3) == 0);
      wait_cycles = fast_receiver ? 0 : int'($urandom_range(0, 7));
      // one long hold-off so the block backs up into the character side
      if (tokens_seen == 30) wait_cycles = 120;
      if (wait_cycles > 0) begin
        tok_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      tok_stall <= 1'b0;
      do @(posedge clk); while (tok_valid !== 1'b1);
      got.kind = kind_t'(token_kind);
      got.mant = mantissa;
      got.frac = frac_digits;
      got.pos  = stop_position;
      got.last = last_of_item;
      sb.check(got, $time);
      tokens_seen++;
    end
  end

  // character side and configuration
  initial begin
    ch        <= CH_NUL;
    ch_valid  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PARAM_PREFIX;
    cfg_data  <= '0;
    rst       <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // long fraction, number end, parameter, operators, mnemonic, broken mnemonic
    send_text("9.0123456789=P7+-*/EQUEQX");
    send_char(CH_NUL);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_config(PHASE_PREFIX[p], PHASE_OFFSET[p]);
      if (p == PHASES - 1) send_dense_line();
      while (items_sent < PHASE_ITEMS[p]) send_line();
    end

    settle();
    if (sb.errors == 0) begin
      $display("arithmetic_expression_lexer_test passed");
    end else begin
      $display("arithmetic_expression_lexer_test failed");
    end
    $finish;
  end

endmodule
